[hw/rtl/ole_pkg.sv]
// Package for the ordered list engine: command, status and compare codes,
// and the result beat that the sequencer hands to the output register.
// No dependencies.
package ole_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned SIZE_W  = 6;

   typedef enum logic [2:0] {
      CMD_APPEND    = 3'd0,
      CMD_PREPEND   = 3'd1,
      CMD_SORTED    = 3'd2,
      CMD_REMOVE    = 3'd3,
      CMD_POP_FRONT = 3'd4,
      CMD_POP_BACK  = 3'd5,
      CMD_SIZE      = 3'd6,
      CMD_DUMP      = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_EMPTY     = 2'd1,
      STS_NOT_FOUND = 2'd2,
      STS_FULL      = 2'd3
   } status_type;

   // What the shared compare unit reports as a hit for the current entry
   typedef enum logic [1:0] {
      CMP_NEVER  = 2'd0,
      CMP_ALWAYS = 2'd1,
      CMP_GE     = 2'd2,
      CMP_EQ     = 2'd3
   } cmp_mode_type;

   typedef struct packed {
      logic               valid;
      status_type         status;
      logic [VALUE_W-1:0] element;
      logic [SIZE_W-1:0]  size;
      logic               is_empty;
      logic               last;
   } result_type;

endpackage

[hw/rtl/ole_store.sv]
// Entry store of the ordered list engine: one write port, one read port,
// read data registered. Depends on ole_pkg.
module ole_store #(
   parameter int unsigned CAPACITY = 32,
   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [AW-1:0]                    wr_addr,
   input  logic [ole_pkg::VALUE_W-1:0]      wr_data,
   input  logic [AW-1:0]                    rd_addr,
   output logic [ole_pkg::VALUE_W-1:0]      rd_data
);
   import ole_pkg::*;

   logic [VALUE_W-1:0] mem [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;

   // Write one entry per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read every cycle; old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/ole_cmp.sv]
// Shared compare unit of the ordered list engine: checks one stored entry
// against the command value under the selected mode. Depends on ole_pkg.
module ole_cmp (
   input  ole_pkg::cmp_mode_type            mode,
   input  logic [ole_pkg::VALUE_W-1:0]      entry,
   input  logic [ole_pkg::VALUE_W-1:0]      probe,
   output logic                             hit
);
   import ole_pkg::*;

   // Signed order, so the entry is at or above the probe
   always_comb begin
      unique case (mode)
         CMP_NEVER:  hit = 1'b0;
         CMP_ALWAYS: hit = 1'b1;
         CMP_GE:     hit = $signed(entry) >= $signed(probe);
         CMP_EQ:     hit = entry == probe;
         default:    hit = 1'b0;
      endcase
   end

endmodule

[hw/rtl/ole_ctrl.sv]
// Sequencer of the ordered list engine: decodes a command, walks the store
// one entry per cycle to shift, search or dump (a dump holds on a stall),
// and keeps the count. Depends on ole_pkg; drives ole_store and ole_cmp.
module ole_ctrl #(
   parameter int unsigned CAPACITY = 32,
   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_command,
   input  logic [ole_pkg::VALUE_W-1:0]      req_value,
   input  logic                             slot_free,
   output ole_pkg::result_type              res,
   output logic                             wr_en,
   output logic [AW-1:0]                    wr_addr,
   output logic [ole_pkg::VALUE_W-1:0]      wr_data,
   output logic [AW-1:0]                    rd_addr,
   input  logic [ole_pkg::VALUE_W-1:0]      rd_data,
   output ole_pkg::cmp_mode_type            cmp_mode,
   output logic [ole_pkg::VALUE_W-1:0]      cmp_probe,
   input  logic                             cmp_hit
);
   import ole_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WALK   = 4'b0010,
      ST_DUMP   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   state_type          state_ff,  state_in;
   logic [CW-1:0]      count_ff,  count_in;
   logic [CW-1:0]      idx_ff,    idx_in;
   logic [VALUE_W-1:0] carry_ff,  carry_in;
   logic [VALUE_W-1:0] value_ff,  value_in;
   logic               shift_ff,  shift_in;
   logic               remove_ff, remove_in;
   cmp_mode_type       mode_ff,   mode_in;
   status_type         status_ff, status_in;

   logic               in_list;
   logic               is_full;
   logic               is_empty;
   logic               dump_last;
   logic [CW-1:0]      wr_idx;

   assign in_list   = idx_ff < count_ff;
   assign is_full   = count_ff == CAP_C;
   assign is_empty  = count_ff == '0;
   assign dump_last = idx_ff == (count_ff - ONE_C);

   assign req_ready = state_ff == ST_IDLE;
   assign cmp_mode  = mode_ff;
   assign cmp_probe = value_ff;

   // Decode, walk and emit
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      carry_in  = carry_ff;
      value_in  = value_ff;
      shift_in  = shift_ff;
      remove_in = remove_ff;
      mode_in   = mode_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_idx    = idx_ff;
      wr_data   = value_ff;
      res          = '0;
      res.size     = SIZE_W'(count_ff);
      res.is_empty = is_empty;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               value_in  = req_value;
               shift_in  = 1'b0;
               remove_in = 1'b0;
               idx_in    = '0;
               status_in = STS_OK;
               state_in  = ST_FINISH;
               unique case (cmd_type'(req_command))
                  CMD_APPEND: begin
                     if (is_full) begin
                        status_in = STS_FULL;
                     end else begin
                        mode_in  = CMP_NEVER;
                        idx_in   = count_ff;
                        state_in = ST_WALK;
                     end
                  end
                  CMD_PREPEND: begin
                     if (is_full) begin
                        status_in = STS_FULL;
                     end else begin
                        mode_in  = CMP_ALWAYS;
                        state_in = ST_WALK;
                     end
                  end
                  CMD_SORTED: begin
                     if (is_full) begin
                        status_in = STS_FULL;
                     end else begin
                        mode_in  = CMP_GE;
                        state_in = ST_WALK;
                     end
                  end
                  CMD_REMOVE: begin
                     if (is_empty) begin
                        status_in = STS_EMPTY;
                     end else begin
                        mode_in   = CMP_EQ;
                        remove_in = 1'b1;
                        state_in  = ST_WALK;
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (is_empty) begin
                        status_in = STS_EMPTY;
                     end else begin
                        mode_in   = CMP_ALWAYS;
                        remove_in = 1'b1;
                        state_in  = ST_WALK;
                     end
                  end
                  CMD_POP_BACK: begin
                     if (is_empty) begin
                        status_in = STS_EMPTY;
                     end else begin
                        count_in = count_ff - ONE_C;
                     end
                  end
                  CMD_SIZE: begin
                     state_in = ST_FINISH;
                  end
                  CMD_DUMP: begin
                     if (!is_empty) begin
                        state_in = ST_DUMP;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_WALK: begin
            if (in_list) begin
               // Read data holds entry idx; the next read is already in flight
               idx_in = idx_ff + ONE_C;
               if (remove_ff) begin
                  if (shift_ff) begin
                     wr_en   = 1'b1;
                     wr_idx  = idx_ff - ONE_C;
                     wr_data = rd_data;
                  end else if (cmp_hit) begin
                     shift_in = 1'b1;
                  end
               end else begin
                  if (shift_ff) begin
                     wr_en    = 1'b1;
                     wr_data  = carry_ff;
                     carry_in = rd_data;
                  end else if (cmp_hit) begin
                     wr_en    = 1'b1;
                     wr_data  = value_ff;
                     carry_in = rd_data;
                     shift_in = 1'b1;
                  end
               end
            end else begin
               // End of list: close out the insert or the removal
               state_in = ST_FINISH;
               if (remove_ff) begin
                  if (shift_ff) begin
                     count_in = count_ff - ONE_C;
                  end else begin
                     status_in = STS_NOT_FOUND;
                  end
               end else begin
                  wr_en    = 1'b1;
                  wr_data  = shift_ff ? carry_ff : value_ff;
                  count_in = count_ff + ONE_C;
               end
            end
         end

         ST_DUMP: begin
            res.valid   = 1'b1;
            res.status  = STS_OK;
            res.element = rd_data;
            res.last    = dump_last;
            // Advance only when the beat is taken, so the read holds on a stall
            if (slot_free) begin
               idx_in = idx_ff + ONE_C;
               if (dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_FINISH: begin
            res.valid  = 1'b1;
            res.status = status_ff;
            res.last   = 1'b1;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Keep the read address inside the store
   assign rd_addr = (idx_in < CAP_C) ? idx_in[AW-1:0] : '0;
   assign wr_addr = wr_idx[AW-1:0];

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Walk context
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      carry_ff  <= carry_in;
      value_ff  <= value_in;
      shift_ff  <= shift_in;
      remove_ff <= remove_in;
      mode_ff   <= mode_in;
      status_ff <= status_in;
   end

endmodule

[hw/rtl/ordered_list_engine.sv]
// Top level of the ordered list engine: sequencer, entry store, compare
// unit and the result output register. Depends on ole_pkg, ole_store,
// ole_cmp and ole_ctrl.
//
//   channel  direction  ports                                          beats
//   req      in         req_command, req_value                         one per command
//   rsp      out        rsp_status, rsp_element, rsp_size,             one per command,
//                       rsp_is_empty, rsp_last                         count per dump
//
// Size, pop back and commands that fail at once go straight to the final
// step; append passes through the walk state once. Prepend, sorted insert,
// remove and pop front walk the store one entry a cycle, then finish. Dump
// sends one beat per entry, or a single final beat on an empty list.
// req_ready is low for the whole command. Reset (synchronous) empties the
// list; entries are not cleared. An output stall holds the sequencer only
// in the dump and final steps, while a beat waits.
module ordered_list_engine #(
   parameter int unsigned CAPACITY = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [2:0]                            req_command,
   input  logic signed [ole_pkg::VALUE_W-1:0]    req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_status,
   output logic signed [ole_pkg::VALUE_W-1:0]    rsp_element,
   output logic [ole_pkg::SIZE_W-1:0]            rsp_size,
   output logic                                  rsp_is_empty,
   output logic                                  rsp_last
);
   import ole_pkg::*;

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   result_type         res;
   logic               slot_free;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;
   cmp_mode_type       cmp_mode;
   logic [VALUE_W-1:0] cmp_probe;
   logic               cmp_hit;

   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff,       rsp_in;

   ole_ctrl #(.CAPACITY(CAPACITY)) u_ole_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_value   (req_value),
      .slot_free   (slot_free),
      .res         (res),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .cmp_mode    (cmp_mode),
      .cmp_probe   (cmp_probe),
      .cmp_hit     (cmp_hit)
   );

   ole_store #(.CAPACITY(CAPACITY)) u_ole_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ole_cmp u_ole_cmp (
      .mode  (cmp_mode),
      .entry (rd_data),
      .probe (cmp_probe),
      .hit   (cmp_hit)
   );

   // Load a new beat when the register is empty or draining
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (slot_free) begin
         rsp_valid_in = res.valid;
         if (res.valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_ff.status;
   assign rsp_element  = rsp_ff.element;
   assign rsp_size     = rsp_ff.size;
   assign rsp_is_empty = rsp_ff.is_empty;
   assign rsp_last     = rsp_ff.last;

endmodule

[hw/rtl/ole_checker.sv]
// Port checker for the ordered list engine, bound to the top level.
// Depends on ole_pkg and ordered_list_engine.
module ole_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [1:0]                            rsp_status,
   input  logic signed [ole_pkg::VALUE_W-1:0]    rsp_element,
   input  logic [ole_pkg::SIZE_W-1:0]            rsp_size,
   input  logic                                  rsp_is_empty,
   input  logic                                  rsp_last
);
   import ole_pkg::*;

   // An accepted command closes the request side
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an accepted command");

   // Only dump beats can be non-final, and they always report ok
   a_nonlast_is_dump: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == STS_OK)
      else $error("non-final beat with an error status");

   // Error beats carry no element
   a_error_no_element: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_OK |-> rsp_element == '0)
      else $error("error beat carries an element");

   // An empty list reports size zero
   a_empty_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_size == '0)
      else $error("empty flag with nonzero size");

   // A stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element) && $stable(rsp_last))
      else $error("result beat changed while stalled");

endmodule

bind ordered_list_engine ole_checker u_ole_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_status   (rsp_status),
   .rsp_element  (rsp_element),
   .rsp_size     (rsp_size),
   .rsp_is_empty (rsp_is_empty),
   .rsp_last     (rsp_last)
);

[tb/sv/tb_ordered_list_engine.sv]
`timescale 1ns / 1ps
// Self-checking testbench for ordered_list_engine: a queue-fed req driver, a
// stalling rsp sink and a monitor that predicts every result beat.
// Depends on ole_pkg and the ordered_list_engine RTL.
module tb_ordered_list_engine;
   import ole_pkg::*;

   localparam int unsigned LIST_CAPACITY  = 32;
   localparam int unsigned RANDOM_ITEMS   = 260;
   localparam int unsigned DRAIN_CYCLES   = 40;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned REPORT_LIMIT   = 10;

   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      cmd_type            cmd;
      logic signed [31:0] value;
      bit                 wait_idle;
   } list_command_type;

   typedef struct {
      status_type         status;
      logic signed [31:0] element;
      logic [5:0]         size;
      logic               is_empty;
      logic               last;
   } list_reply_type;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [2:0]          req_command = CMD_SIZE;
   logic signed [31:0]  req_value   = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   logic [1:0]          rsp_status;
   logic signed [31:0]  rsp_element;
   logic [5:0]          rsp_size;
   logic                rsp_is_empty;
   logic                rsp_last;

   list_command_type    pending_commands[$];
   list_reply_type      expected_replies[$];
   logic signed [31:0]  plan_list[$];
   logic signed [31:0]  model_list[$];

   bit                  req_beat_taken;
   int unsigned         commands_built;
   int unsigned         commands_taken;
   int unsigned         reply_beats;
   int unsigned         mismatch_count;
   int unsigned         peak_size;
   int unsigned         cmd_seen[8];
   int unsigned         status_seen[4];
   int unsigned         gap_left;
   int unsigned         burst_left;
   int unsigned         stall_mode;
   int unsigned         stall_timer;
   int unsigned         stall_tick;
   int unsigned         idle_cycles;

   ordered_list_engine #(
      .CAPACITY(LIST_CAPACITY)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_element  (rsp_element),
      .rsp_size     (rsp_size),
      .rsp_is_empty (rsp_is_empty),
      .rsp_last     (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one command to a list image and return the status it earns
   function automatic void run_list_command(ref logic signed [31:0] lst[$],
                                            input cmd_type cmd,
                                            input logic signed [31:0] v,
                                            output status_type st);
      int unsigned pos;
      st = STS_OK;
      case (cmd)
         CMD_APPEND, CMD_PREPEND, CMD_SORTED: begin
            if (lst.size() >= LIST_CAPACITY) begin
               st = STS_FULL;
            end else if (cmd == CMD_APPEND) begin
               lst.push_back(v);
            end else if (cmd == CMD_PREPEND) begin
               lst.push_front(v);
            end else begin
               // go in ahead of the first entry not below the value
               pos = 0;
               while (pos < lst.size() && lst[pos] < v) pos++;
               lst.insert(pos, v);
            end
         end
         CMD_REMOVE: begin
            if (lst.size() == 0) begin
               st = STS_EMPTY;
            end else begin
               pos = 0;
               while (pos < lst.size() && lst[pos] != v) pos++;
               if (pos == lst.size()) st = STS_NOT_FOUND;
               else lst.delete(pos);
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (lst.size() == 0) st = STS_EMPTY;
            else if (cmd == CMD_POP_FRONT) void'(lst.pop_front());
            else void'(lst.pop_back());
         end
         default: ;
      endcase
   endfunction

   // Queue a command and advance the planning image so later picks know the list
   task automatic add_command(input cmd_type cmd, input logic signed [31:0] v,
                              input bit hold);
      list_command_type c;
      status_type       st;
      c.cmd       = cmd;
      c.value     = v;
      c.wait_idle = hold;
      pending_commands.push_back(c);
      run_list_command(plan_list, cmd, v, st);
      commands_built++;
   endtask

   // Mix extremes, a narrow band that makes duplicates, stored values and noise
   function automatic logic signed [31:0] pick_value();
      logic signed [31:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: v = VAL_MIN;
               1: v = VAL_MAX;
               2: v = 0;
               3: v = -1;
               default: v = 1;
            endcase
         end
         1, 2, 3: v = $signed($urandom_range(0, 16)) - 8;
         4, 5: begin
            if (plan_list.size() != 0) v = plan_list[$urandom_range(0, plan_list.size() - 1)];
            else v = $urandom;
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic build_stimulus();
      int unsigned phase_kind;
      int unsigned phase_len;
      int unsigned r;
      bit          hold;
      cmd_type     cmd;
      logic signed [31:0] v;

      // Directed: empty-list errors, extremes, equal keys, missing value
      add_command(CMD_DUMP,      0, 1'b0);
      add_command(CMD_POP_FRONT, 0, 1'b0);
      add_command(CMD_POP_BACK,  0, 1'b0);
      add_command(CMD_REMOVE,    0, 1'b0);
      add_command(CMD_SIZE,      0, 1'b0);
      add_command(CMD_APPEND,    VAL_MAX, 1'b0);
      add_command(CMD_PREPEND,   VAL_MIN, 1'b0);
      add_command(CMD_SORTED,    0, 1'b0);
      add_command(CMD_SORTED,    0, 1'b0);
      add_command(CMD_SORTED,    -1, 1'b0);
      add_command(CMD_SORTED,    VAL_MAX, 1'b0);
      add_command(CMD_SORTED,    1, 1'b0);
      add_command(CMD_APPEND,    32'shAAAA_AAAA, 1'b0);
      add_command(CMD_SORTED,    32'sh5555_5555, 1'b0);
      add_command(CMD_REMOVE,    12345, 1'b0);
      add_command(CMD_DUMP,      32'shFFFF_FFFF, 1'b0);
      add_command(CMD_REMOVE,    VAL_MAX, 1'b0);
      add_command(CMD_POP_FRONT, 0, 1'b0);
      add_command(CMD_POP_BACK,  0, 1'b0);
      add_command(CMD_SIZE,      0, 1'b0);
      add_command(CMD_REMOVE,    0, 1'b0);
      add_command(CMD_DUMP,      0, 1'b0);

      // Fill to capacity from a drained pipe, then hit the full store
      hold = 1'b1;
      while (plan_list.size() < LIST_CAPACITY) begin
         cmd = cmd_type'($urandom_range(0, 2));
         add_command(cmd, pick_value(), hold);
         hold = 1'b0;
      end
      add_command(CMD_APPEND,  pick_value(), 1'b0);
      add_command(CMD_PREPEND, pick_value(), 1'b0);
      add_command(CMD_SORTED,  pick_value(), 1'b0);
      add_command(CMD_DUMP,    pick_value(), 1'b0);

      // Random phases: grow, shrink and churn with random content
      while (commands_built < 22 + RANDOM_ITEMS) begin
         phase_kind = $urandom_range(0, 2);
         phase_len  = $urandom_range(10, 45);
         hold       = ($urandom_range(0, 3) == 0);
         repeat (phase_len) begin
            r = $urandom_range(0, 9);
            case (phase_kind)
               0: begin
                  if (r < 3) cmd = CMD_APPEND;
                  else if (r < 5) cmd = CMD_PREPEND;
                  else if (r < 8) cmd = CMD_SORTED;
                  else if (r == 8) cmd = ($urandom_range(0, 1) != 0) ? CMD_DUMP : CMD_SIZE;
                  else cmd = cmd_type'($urandom_range(3, 5));
               end
               1: begin
                  if (r < 3) cmd = CMD_REMOVE;
                  else if (r < 5) cmd = CMD_POP_FRONT;
                  else if (r < 7) cmd = CMD_POP_BACK;
                  else if (r == 7) cmd = CMD_DUMP;
                  else if (r == 8) cmd = CMD_SIZE;
                  else cmd = cmd_type'($urandom_range(0, 2));
               end
               default: cmd = cmd_type'($urandom_range(0, 7));
            endcase
            // removes mostly name a stored value so they hit
            if (cmd == CMD_REMOVE && plan_list.size() != 0 && $urandom_range(0, 9) < 7)
               v = plan_list[$urandom_range(0, plan_list.size() - 1)];
            else
               v = pick_value();
            add_command(cmd, v, hold);
            hold = 1'b0;
         end
      end
   endtask

   // Drive req beats in bursts; hold a beat until taken; pause on a drain marker
   always @(negedge clock) begin : req_driver
      list_command_type beat_cmd;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_beat_taken) begin
         // hold the current beat
      end else if (gap_left != 0) begin
         gap_left = gap_left - 1;
         req_valid <= 1'b0;
      end else if (pending_commands.size() == 0) begin
         req_valid <= 1'b0;
      end else if (pending_commands[0].wait_idle && expected_replies.size() != 0) begin
         req_valid <= 1'b0;
      end else begin
         beat_cmd = pending_commands.pop_front();
         req_valid   <= 1'b1;
         req_command <= beat_cmd.cmd;
         req_value   <= beat_cmd.value;
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 9))
               0, 1, 2, 3: gap_left = 0;
               9:          gap_left = $urandom_range(8, 20);
               default:    gap_left = $urandom_range(1, 4);
            endcase
         end else begin
            burst_left = burst_left - 1;
         end
      end
   end

   // Stall rsp on a pattern whose mode changes each time a random timer expires
   always @(negedge clock) begin : rsp_sink
      if (stall_timer == 0) begin
         stall_mode  = $urandom_range(0, 3);
         stall_timer = $urandom_range(20, 80);
      end else begin
         stall_timer = stall_timer - 1;
      end
      stall_tick = stall_tick + 1;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) != 0);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ((stall_tick % 7) < 4);
      endcase
   end

   // Predict on each req beat, then check each rsp beat against the oldest prediction
   always @(posedge clock) begin : monitor
      cmd_type        cmd;
      status_type     st;
      list_reply_type reply;
      list_reply_type want;
      req_beat_taken = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_beat_taken = 1'b1;
            commands_taken++;
            cmd = cmd_type'(req_command);
            cmd_seen[cmd]++;
            run_list_command(model_list, cmd, req_value, st);
            status_seen[st]++;
            if (model_list.size() > peak_size) peak_size = model_list.size();
            reply.status   = st;
            reply.element  = 0;
            reply.size     = 6'(model_list.size());
            reply.is_empty = (model_list.size() == 0);
            reply.last     = 1'b1;
            if (cmd == CMD_DUMP && model_list.size() != 0) begin
               foreach (model_list[i]) begin
                  reply.element = model_list[i];
                  reply.last    = (i == model_list.size() - 1);
                  expected_replies.push_back(reply);
               end
            end else begin
               expected_replies.push_back(reply);
            end
         end
         if (rsp_valid && rsp_ready) begin
            reply_beats++;
            if (expected_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: rsp beat with nothing expected: status %0d element %0d size %0d",
                           $time, rsp_status, rsp_element, rsp_size);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status || rsp_element !== want.element ||
                   rsp_size !== want.size || rsp_is_empty !== want.is_empty ||
                   rsp_last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"%0t: rsp mismatch (expected/actual) status %0d/%0d ",
                               "element %0d/%0d size %0d/%0d is_empty %0b/%0b last %0b/%0b"},
                              $time, want.status, rsp_status, want.element, rsp_element,
                              want.size, rsp_size, want.is_empty, rsp_is_empty,
                              want.last, rsp_last);
               end
            end
         end
      end
   end

   // End the run if no beat moves on either channel for too long
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_replies.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      build_stimulus();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every command to be taken and every result to drain
      do @(posedge clock);
      while (pending_commands.size() != 0 || commands_taken != commands_built ||
             expected_replies.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_replies.size() != 0) begin
         mismatch_count++;
         $display("%0d result beats never arrived", expected_replies.size());
      end

      $display("Ran %0d commands (append %0d prepend %0d sorted %0d remove %0d pop front %0d %s",
               commands_taken, cmd_seen[CMD_APPEND], cmd_seen[CMD_PREPEND],
               cmd_seen[CMD_SORTED], cmd_seen[CMD_REMOVE], cmd_seen[CMD_POP_FRONT],
               $sformatf("pop back %0d size %0d dump %0d), %0d result beats, peak size %0d",
                         cmd_seen[CMD_POP_BACK], cmd_seen[CMD_SIZE], cmd_seen[CMD_DUMP],
                         reply_beats, peak_size));
      $display("Statuses: ok %0d, empty %0d, not found %0d, full %0d; %0d mismatches",
               status_seen[STS_OK], status_seen[STS_EMPTY], status_seen[STS_NOT_FOUND],
               status_seen[STS_FULL], mismatch_count);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
